// ----- src/mcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle point generator package
// Shared widths, codes and the group record passed from front to back end.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int RADIUS_BITS = 14;
  localparam int OFF_W       = RADIUS_BITS;
  localparam int ERR_W       = RADIUS_BITS + 3;
  localparam int CENTER_W    = 15;
  localparam int RAD_IN_W    = 14;
  localparam int COORD_W     = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PT_IDX_W    = 3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Octant order of the eight points of a group.
  localparam logic [PT_IDX_W-1:0] PT_PX_PY = 3'd0;
  localparam logic [PT_IDX_W-1:0] PT_PY_PX = 3'd1;
  localparam logic [PT_IDX_W-1:0] PT_NY_PX = 3'd2;
  localparam logic [PT_IDX_W-1:0] PT_NX_PY = 3'd3;
  localparam logic [PT_IDX_W-1:0] PT_NX_NY = 3'd4;
  localparam logic [PT_IDX_W-1:0] PT_NY_NX = 3'd5;
  localparam logic [PT_IDX_W-1:0] PT_PY_NX = 3'd6;
  localparam logic [PT_IDX_W-1:0] PT_PX_NY = 3'd7;

  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [OFF_W-1:0]           ox;
    logic [OFF_W-1:0]           oy;
    logic                       done;
  } grp_t;

endpackage

// ----- src/midpoint_circle_point_generator_core.sv -----
// A group's first point passes through the group queue, the back end's group
// register and the output register. The point sequencer emits eight points per
// emitting request, one point per cycle while out_stall is low; idle steps and
// zero radius starts emit none. The two-entry group queue absorbs requests.
// Reset (synchronous, rst_n low) idles the generator and empties the queue.
// ----------------------------------------------------------------------------
// Midpoint circle point generator core
// Front end runs the midpoint iteration, back end emits the eight points.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_core
  import mcpg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic signed [CENTER_W-1:0] in_center_x,
  input  logic signed [CENTER_W-1:0] in_center_y,
  input  logic [RAD_IN_W-1:0]        in_radius,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  out_point_x,
  output logic signed [COORD_W-1:0]  out_point_y,
  output logic                       out_last_of_group,
  output logic                       out_circle_done
);

  logic q_push, q_pop, q_full, q_not_empty;
  grp_t q_wdata, q_rdata;

  mcpg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  mcpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  mcpg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_last_of_group (out_last_of_group),
    .out_circle_done   (out_circle_done)
  );

endmodule

// ----- src/mcpg_front.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle front end
// Accepts start and step requests, keeps the midpoint iteration state and
// hands one group record per emitting request to the queue.
// ----------------------------------------------------------------------------
module mcpg_front
  import mcpg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic signed [CENTER_W-1:0] in_center_x,
  input  logic signed [CENTER_W-1:0] in_center_y,
  input  logic [RAD_IN_W-1:0]        in_radius,
  input  logic                       q_full,
  output logic                       q_push,
  output grp_t                       q_data
);

  logic                       active_r, active_nxt;
  logic [OFF_W-1:0]           x_r, x_nxt;
  logic [OFF_W-1:0]           y_r, y_nxt;
  logic signed [ERR_W-1:0]    err_r, err_nxt;
  logic signed [CENTER_W-1:0] cx_r, cx_nxt;
  logic signed [CENTER_W-1:0] cy_r, cy_nxt;

  logic                       accept;
  logic                       is_start;
  logic [OFF_W-1:0]           rad;
  logic                       rad_zero;
  logic [OFF_W-1:0]           cur_x, cur_y, adv_x, adv_y;
  logic signed [ERR_W-1:0]    cur_err, adv_err, dy2, dyx2;
  logic signed [CENTER_W-1:0] cur_cx, cur_cy;
  logic                       adv_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_start = (in_op == OP_START);
  assign rad      = OFF_W'(in_radius);
  assign rad_zero = (rad == '0);

  always_comb begin
    if (is_start) begin
      cur_x   = rad;
      cur_y   = '0;
      cur_err = ERR_W'(1) - $signed(ERR_W'(rad));
      cur_cx  = in_center_x;
      cur_cy  = in_center_y;
    end else begin
      cur_x   = x_r;
      cur_y   = y_r;
      cur_err = err_r;
      cur_cx  = cx_r;
      cur_cy  = cy_r;
    end
  end

  // One midpoint step: y always advances, x drops when the midpoint is outside.
  always_comb begin
    adv_y = cur_y + OFF_W'(1);
    dy2   = $signed(ERR_W'(adv_y) <<< 1) + ERR_W'(1);
    if (cur_err <= 0) begin
      adv_x   = cur_x;
      dyx2    = '0;
      adv_err = cur_err + dy2;
    end else begin
      adv_x   = cur_x - OFF_W'(1);
      dyx2    = (($signed(ERR_W'(adv_y)) - $signed(ERR_W'(adv_x))) <<< 1) + ERR_W'(1);
      adv_err = cur_err + dyx2;
    end
    adv_done = (adv_x < adv_y);
  end

  always_comb begin
    q_push      = accept && (is_start ? !rad_zero : active_r);
    q_data.cx   = cur_cx;
    q_data.cy   = cur_cy;
    q_data.ox   = cur_x;
    q_data.oy   = cur_y;
    q_data.done = adv_done;

    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    err_nxt    = err_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    if (accept && is_start && rad_zero) begin
      active_nxt = 1'b0;
    end else if (q_push) begin
      active_nxt = !adv_done;
      x_nxt      = adv_x;
      y_nxt      = adv_y;
      err_nxt    = adv_err;
      cx_nxt     = cur_cx;
      cy_nxt     = cur_cy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else begin
      active_r <= active_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      err_r    <= err_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
    end
  end

endmodule

// ----- src/mcpg_queue.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle group queue
// Short FIFO of group records between the front and back ends.
// ----------------------------------------------------------------------------
module mcpg_queue
  import mcpg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  input  logic pop,
  output grp_t pop_data,
  output logic full,
  output logic not_empty
);

  grp_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/mcpg_back.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle back end
// Expands each group record into eight points, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module mcpg_back
  import mcpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  grp_t                      q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic                      out_last_of_group,
  output logic                      out_circle_done
);

  grp_t                      grp_r, grp_nxt;
  logic                      busy_r, busy_nxt;
  logic [PT_IDX_W-1:0]       idx_r, idx_nxt;
  logic                      ovld_r, ovld_nxt;
  logic signed [COORD_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic                      last_r, done_r, last_nxt, done_nxt;

  logic                      adv;
  logic                      is_last;
  logic signed [COORD_W-1:0] cx16, cy16, ox16, oy16;

  assign adv     = !ovld_r || !out_stall;
  assign is_last = (idx_r == PT_PX_NY);
  assign q_pop   = q_not_empty && (!busy_r || (adv && is_last));

  assign cx16 = COORD_W'(grp_r.cx);
  assign cy16 = COORD_W'(grp_r.cy);
  assign ox16 = $signed(COORD_W'(grp_r.ox));
  assign oy16 = $signed(COORD_W'(grp_r.oy));

  always_comb begin
    case (idx_r)
      PT_PX_PY: begin px_nxt = cx16 + ox16; py_nxt = cy16 + oy16; end
      PT_PY_PX: begin px_nxt = cx16 + oy16; py_nxt = cy16 + ox16; end
      PT_NY_PX: begin px_nxt = cx16 - oy16; py_nxt = cy16 + ox16; end
      PT_NX_PY: begin px_nxt = cx16 - ox16; py_nxt = cy16 + oy16; end
      PT_NX_NY: begin px_nxt = cx16 - ox16; py_nxt = cy16 - oy16; end
      PT_NY_NX: begin px_nxt = cx16 - oy16; py_nxt = cy16 - ox16; end
      PT_PY_NX: begin px_nxt = cx16 + oy16; py_nxt = cy16 - ox16; end
      PT_PX_NY: begin px_nxt = cx16 + ox16; py_nxt = cy16 - oy16; end
      default:  begin px_nxt = cx16;        py_nxt = cy16;        end
    endcase
    last_nxt = is_last;
    done_nxt = is_last && grp_r.done;
  end

  always_comb begin
    grp_nxt  = grp_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ovld_nxt = ovld_r;
    if (adv) begin
      ovld_nxt = busy_r;
    end
    if (busy_r && adv) begin
      idx_nxt = idx_r + PT_IDX_W'(1);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    // A new group loads while idle or right behind the last point of the
    // current one, so groups run back to back.
    if (q_pop) begin
      grp_nxt  = q_data;
      busy_nxt = 1'b1;
      idx_nxt  = PT_PX_PY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= PT_PX_PY;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    if (adv && busy_r) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid         = ovld_r;
  assign out_point_x       = px_r;
  assign out_point_y       = py_r;
  assign out_last_of_group = last_r;
  assign out_circle_done   = done_r;

endmodule

// ----- src/mcpg_checker.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle port checker
// Checks the core's output ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mcpg_checker
  import mcpg_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] out_point_x,
  input logic signed [COORD_W-1:0] out_point_y,
  input logic                      out_last_of_group,
  input logic                      out_circle_done
);

  // A stalled point holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) &&
      $stable(out_point_y) && $stable(out_last_of_group))
    else $error("stalled output point changed");

  // The circle finishes only on the last point of a group.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_circle_done |-> out_last_of_group)
    else $error("circle_done without last_of_group");

  // Within a group the points follow each other without gaps.
  a_group_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_group |=> out_valid)
    else $error("gap inside a group of points");

  // Reset empties the output.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind midpoint_circle_point_generator_core mcpg_checker u_mcpg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_point_x       (out_point_x),
  .out_point_y       (out_point_y),
  .out_last_of_group (out_last_of_group),
  .out_circle_done   (out_circle_done)
);

// ----- bench/midpoint_circle_point_generator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle point generator core testbench
// Sends start and step requests and tracks the midpoint iteration alongside
// the core. Every plotted point is checked in order against that tracking,
// while both sides of the core idle at random over the first two thirds of the requests.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_core_tb
  import mcpg_pkg::*;
();

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 220;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic                       op;
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [RAD_IN_W-1:0]        radius;
  } circle_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last;
    logic                      done;
  } point_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_op = OP_STEP;
  logic signed [CENTER_W-1:0] in_center_x = '0;
  logic signed [CENTER_W-1:0] in_center_y = '0;
  logic [RAD_IN_W-1:0]        in_radius = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [COORD_W-1:0]  out_point_x;
  logic signed [COORD_W-1:0]  out_point_y;
  logic                       out_last_of_group;
  logic                       out_circle_done;

  midpoint_circle_point_generator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_group(out_last_of_group),
    .out_circle_done  (out_circle_done)
  );

  always #CLK_HALF clk = ~clk;

  circle_req_t circle_reqs[$];
  point_t      expected_points[$];
  circle_req_t drv_req;
  logic        in_took = 1'b0;
  int          sent_count = 0;
  int          total_reqs = 1;
  int          fail_count = 0;
  int          cycle_count = 0;

  // Tracked iteration state of the core.
  logic                       trk_active = 1'b0;
  logic [OFF_W-1:0]           trk_ox = '0;
  logic [OFF_W-1:0]           trk_oy = '0;
  logic signed [ERR_W-1:0]    trk_err = '0;
  logic signed [CENTER_W-1:0] trk_cx = '0;
  logic signed [CENTER_W-1:0] trk_cy = '0;

  // Stimulus side: groups still to come for the circle being requested.
  int gen_left = 0;

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTS) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic int group_count(int r);
    int x, y, e, n;
    x = r;
    y = 0;
    e = 1 - r;
    n = 0;
    do begin
      y++;
      if (e <= 0) begin
        e += 2 * y + 1;
      end else begin
        x--;
        e += 2 * (y - x) + 1;
      end
      n++;
    end while (x >= y);
    return n;
  endfunction

  task automatic queue_point(int px, int py, logic last, logic done);
    point_t p;
    p.px   = px[COORD_W-1:0];
    p.py   = py[COORD_W-1:0];
    p.last = last;
    p.done = done;
    expected_points = {expected_points, p};
  endtask

  // Eight points from the current offsets, then one midpoint step.
  task automatic plot_octants();
    int  cx, cy, ox, oy, nx, ny, e;
    logic fin;
    cx = trk_cx;
    cy = trk_cy;
    ox = trk_ox;
    oy = trk_oy;
    e  = trk_err;
    nx = ox;
    ny = oy + 1;
    if (e <= 0) begin
      e += 2 * ny + 1;
    end else begin
      nx -= 1;
      e += 2 * (ny - nx) + 1;
    end
    fin = (nx < ny);
    queue_point(cx + ox, cy + oy, 1'b0, 1'b0);
    queue_point(cx + oy, cy + ox, 1'b0, 1'b0);
    queue_point(cx - oy, cy + ox, 1'b0, 1'b0);
    queue_point(cx - ox, cy + oy, 1'b0, 1'b0);
    queue_point(cx - ox, cy - oy, 1'b0, 1'b0);
    queue_point(cx - oy, cy - ox, 1'b0, 1'b0);
    queue_point(cx + oy, cy - ox, 1'b0, 1'b0);
    queue_point(cx + ox, cy - oy, 1'b1, fin);
    trk_ox  = OFF_W'(nx);
    trk_oy  = OFF_W'(ny);
    trk_err = ERR_W'(e);
    if (fin) trk_active = 1'b0;
  endtask

  task automatic apply_request(circle_req_t q);
    int r;
    if (q.op == OP_START) begin
      r = q.radius;
      if (r == 0) begin
        trk_active = 1'b0;
      end else begin
        trk_cx     = q.cx;
        trk_cy     = q.cy;
        trk_ox     = OFF_W'(r);
        trk_oy     = '0;
        trk_err    = ERR_W'(1 - r);
        trk_active = 1'b1;
        plot_octants();
      end
    end else if (trk_active) begin
      plot_octants();
    end
  endtask

  task automatic push_start(int cx, int cy, int r);
    circle_req_t q;
    q.op     = OP_START;
    q.cx     = cx[CENTER_W-1:0];
    q.cy     = cy[CENTER_W-1:0];
    q.radius = r[RAD_IN_W-1:0];
    circle_reqs = {circle_reqs, q};
    if (q.radius != 0) begin
      gen_left = group_count(q.radius) - 1;
    end else begin
      gen_left = 0;
    end
  endtask

  // Center and radius of a step are ignored, so they carry random bits.
  task automatic push_step();
    circle_req_t q;
    int          rnd;
    q.op     = OP_STEP;
    rnd      = $urandom;
    q.cx     = rnd[CENTER_W-1:0];
    rnd      = $urandom;
    q.cy     = rnd[CENTER_W-1:0];
    rnd      = $urandom;
    q.radius = rnd[RAD_IN_W-1:0];
    circle_reqs = {circle_reqs, q};
    if (gen_left > 0) begin
      gen_left--;
    end
  endtask

  function automatic int rand_coord();
    return $urandom_range(0, 32767) - 16384;
  endfunction

  // Inputs change at the falling edge.
  always @(negedge clk) begin
    int phase;
    int idle_pct;
    int stall_pct;
    phase = (sent_count * 3) / total_reqs;
    idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 56 : 0;
    stall_pct = (phase == 0) ? 56 : (phase == 1) ? 34 : 0;
    if (rst_n) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (!in_valid || in_took) begin
        if (circle_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_req = circle_reqs.pop_front();
          sent_count++;
          in_valid    <= 1'b1;
          in_op       <= drv_req.op;
          in_center_x <= drv_req.cx;
          in_center_y <= drv_req.cy;
          in_radius   <= drv_req.radius;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Requests are predicted before points are checked, so a point can never
  // be compared ahead of the request that causes it.
  always @(posedge clk) begin
    point_t want;
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) apply_request(drv_req);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("point (%0d,%0d) with none expected",
                                  out_point_x, out_point_y));
      end else begin
        want = expected_points.pop_front();
        if (out_point_x !== want.px)
          report_mismatch($sformatf("point_x %0d, expected %0d", out_point_x, want.px));
        if (out_point_y !== want.py)
          report_mismatch($sformatf("point_y %0d, expected %0d", out_point_y, want.py));
        if (out_last_of_group !== want.last)
          report_mismatch($sformatf("last_of_group %0b, expected %0b",
                                    out_last_of_group, want.last));
        if (out_circle_done !== want.done)
          report_mismatch($sformatf("circle_done %0b, expected %0b",
                                    out_circle_done, want.done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int pick, r, steps, i;

    // Directed: idle steps, zero radius, coordinate extremes, abandoning.
    push_step();
    push_start(16383, -16384, 0);
    push_step();
    push_start(16383, -16384, 1);
    push_step();
    push_step();
    push_start(-16384, 16383, 16383);
    push_step();
    push_step();
    push_start(16383, -16384, 16383);
    push_step();
    push_start(-1, -1, 3);
    push_step();
    push_step();
    push_step();
    push_start(0, 0, 5);
    push_step();
    push_start(100, -100, 0);
    push_step();
    push_start(-16384, -16384, 2);
    push_step();
    push_step();

    // Random: mostly whole circles, some abandoned, plus stray requests.
    while (circle_reqs.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          push_start(rand_coord(), rand_coord(), $urandom_range(41, 16383));
          steps = $urandom_range(0, 6);
        end else begin
          push_start(rand_coord(), rand_coord(), $urandom_range(1, 40));
          steps = gen_left;
          if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, gen_left);
          else if ($urandom_range(0, 3) == 0) steps = gen_left + 1;
        end
        for (i = 0; i < steps; i++) push_step();
      end else if (pick < 90) begin
        push_step();
      end else if (pick < 95) begin
        push_start(rand_coord(), rand_coord(), 0);
      end else begin
        r = $urandom_range(0, 16383);
        push_start(rand_coord(), rand_coord(), r);
        push_step();
      end
    end
    total_reqs = circle_reqs.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (circle_reqs.size() != 0 || in_valid || expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_points.size() != 0)
      report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mcpg_pkg.sv
src/mcpg_front.sv
src/mcpg_queue.sv
src/mcpg_back.sv
src/midpoint_circle_point_generator_core.sv
src/mcpg_checker.sv
bench/midpoint_circle_point_generator_core_tb.sv
